// File: rtl/fdsd_pkg.sv
// Shared types, command codes and glyph table for the segment display controller.
`timescale 1ns / 1ps

package fdsd_pkg;

    localparam int CELL_MAX   = 8;
    localparam int SHOW_CELLS = 4;

    localparam logic [2:0] FUNC_SET_DIGIT = 3'd0;
    localparam logic [2:0] FUNC_SHOW_NUM  = 3'd1;
    localparam logic [2:0] FUNC_TICK      = 3'd2;
    localparam logic [2:0] FUNC_DOTS_ON   = 3'd3;
    localparam logic [2:0] FUNC_DOTS_OFF  = 3'd4;
    localparam logic [2:0] FUNC_DOTS_TGL  = 3'd5;
    localparam logic [2:0] FUNC_CLEAR     = 3'd6;
    localparam logic [2:0] FUNC_LOAD_TIME = 3'd7;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_BAD_POS = 2'd1;
    localparam logic [1:0] STAT_BAD_DIG = 2'd2;
    localparam logic [1:0] STAT_BAD_NUM = 2'd3;

    localparam logic [7:0] BLANK_CODE = 8'hFF;
    localparam logic [6:0] GLYPH_E    = 7'h79;
    localparam logic [6:0] GLYPH_R    = 7'h50;

    typedef logic [3:0] t_digit;
    typedef t_digit [CELL_MAX-1:0] t_digit_arr;
    typedef logic [7:0] t_cell;

    function automatic logic [6:0] hex_glyph(input logic [3:0] d);
        logic [6:0] g;
        case (d)
            4'h0:    g = 7'h3F;
            4'h1:    g = 7'h06;
            4'h2:    g = 7'h5B;
            4'h3:    g = 7'h4F;
            4'h4:    g = 7'h66;
            4'h5:    g = 7'h6D;
            4'h6:    g = 7'h7D;
            4'h7:    g = 7'h07;
            4'h8:    g = 7'h7F;
            4'h9:    g = 7'h6F;
            4'hA:    g = 7'h77;
            4'hB:    g = 7'h7C;
            4'hC:    g = 7'h39;
            4'hD:    g = 7'h5E;
            4'hE:    g = 7'h79;
            default: g = 7'h71;
        endcase
        return g;
    endfunction

endpackage

// File: rtl/fdsd_num_conv.sv
// Number to digit conversion for radix 2, 8, 10 and 16, with range check.
`timescale 1ns / 1ps

module fdsd_num_conv (
    input  logic [23:0]         i_number,
    input  logic [4:0]          i_base,
    output logic                o_ok,
    output fdsd_pkg::t_digit_arr o_digit,
    output logic [fdsd_pkg::CELL_MAX-1:0] o_zero
);
    import fdsd_pkg::*;

    logic [13:0] w_dec;
    logic [27:0] w_p1;
    logic [27:0] w_p2;
    logic [27:0] w_p3;
    logic [9:0]  w_q1;
    logic [6:0]  w_q2;
    logic [3:0]  w_q3;
    logic [13:0] w_r0;
    logic [9:0]  w_r1;
    logic [6:0]  w_r2;
    logic [31:0] w_bin;
    logic        w_b2;
    logic        w_b8;
    logic        w_b10;
    logic        w_b16;

    assign w_b2  = (i_base == 5'd2);
    assign w_b8  = (i_base == 5'd8);
    assign w_b10 = (i_base == 5'd10);
    assign w_b16 = (i_base == 5'd16);

    assign o_ok = (w_b10 && i_number <= 24'd9999) || (w_b2 && i_number <= 24'd15) ||
                  (w_b8 && i_number <= 24'd4095) || (w_b16 && i_number <= 24'd65535);

    // decimal: reciprocal multiplies, exact for values up to 9999
    assign w_dec = i_number[13:0];
    assign w_p1  = {14'd0, w_dec} * 28'd6554;
    assign w_p2  = {14'd0, w_dec} * 28'd5243;
    assign w_p3  = {14'd0, w_dec} * 28'd8389;
    assign w_q1  = w_p1[25:16];
    assign w_q2  = w_p2[25:19];
    assign w_q3  = w_p3[26:23];
    assign w_r0  = w_dec - ({1'b0, w_q1, 3'd0} + {3'd0, w_q1, 1'b0});
    assign w_r1  = w_q1 - ({w_q2, 3'd0} + {2'd0, w_q2, 1'b0});
    assign w_r2  = w_q2 - ({w_q3[3:0], 3'd0} + {2'd0, w_q3, 1'b0});

    assign w_bin = {16'd0, i_number[15:0]};

    always_comb begin
        o_digit = '0;
        o_zero  = '1;
        if (w_b10) begin
            o_digit[0] = w_r0[3:0];
            o_digit[1] = w_r1[3:0];
            o_digit[2] = w_r2[3:0];
            o_digit[3] = w_q3;
            o_zero[0]  = (w_q1 == 10'd0);
            o_zero[1]  = (w_q2 == 7'd0);
            o_zero[2]  = (w_q3 == 4'd0);
        end else begin
            for (int k = 0; k < CELL_MAX; k++) begin
                if (w_b2) begin
                    o_digit[k] = {3'd0, w_bin[k]};
                    o_zero[k]  = ((w_bin >> (k + 1)) == 32'd0);
                end else if (w_b8) begin
                    o_digit[k] = {1'b0, w_bin[3*k +: 3]};
                    o_zero[k]  = ((w_bin >> (3 * (k + 1))) == 32'd0);
                end else begin
                    o_digit[k] = (k < 7) ? w_bin[4*k +: 4] : 4'd0;
                    o_zero[k]  = (k < 3) ? ((w_bin >> (4 * (k + 1))) == 32'd0) : 1'b1;
                end
            end
        end
    end

endmodule

// File: rtl/four_digit_segment_display_controller_core.sv
// A command goes from the input register to the result register before its output transfer.
// Throughput: one command per cycle unless stalled; each updates image and clock in one pass.
// A stalled result holds the pipe; the input register still takes one command meanwhile.
// Reset (synchronous, active low): image blank with all dots off, clock at 00:00:00,
// both pipeline stages empty.
`timescale 1ns / 1ps

module four_digit_segment_display_controller_core #(
    parameter int DIGIT_COUNT = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // digit_value[7:0], position[10:8], number[34:11], base[39:35], blank_leading[40],
    // dot_mask[44:41], load_hours[49:45], load_minutes[55:50], load_seconds[61:56]
    input  logic [63:0] s_tdata,
    // func[2:0]
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // segments_digit1[7:0], segments_digit2[15:8], segments_digit3[23:16],
    // segments_digit4[31:24], status[33:32], hours_now[38:34], minutes_now[44:39],
    // seconds_now[50:45]
    output logic [55:0] m_tdata
);
    import fdsd_pkg::*;

    logic        r_in_valid;
    logic [2:0]  r_func;
    logic [7:0]  r_dval;
    logic [2:0]  r_pos;
    logic [23:0] r_num;
    logic [4:0]  r_base;
    logic        r_blank;
    logic [3:0]  r_mask;
    logic [4:0]  r_lh;
    logic [5:0]  r_lm;
    logic [5:0]  r_ls;

    t_cell       r_cell [SHOW_CELLS];
    logic [4:0]  r_hours;
    logic [5:0]  r_min;
    logic [5:0]  r_sec;

    t_cell       n_cell [SHOW_CELLS];
    logic [4:0]  n_hours;
    logic [5:0]  n_min;
    logic [5:0]  n_sec;
    logic [1:0]  n_status;

    logic        r_out_valid;
    logic [55:0] r_out;

    logic        w_adv;
    logic        w_fire;
    logic        w_num_ok;
    t_digit_arr  w_digit;
    logic [CELL_MAX-1:0] w_zero;

    assign w_adv    = !r_out_valid || m_tready;
    assign w_fire   = r_in_valid && w_adv;
    assign s_tready = !r_in_valid || w_adv;
    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out;

    fdsd_num_conv u_conv (
        .i_number (r_num),
        .i_base   (r_base),
        .o_ok     (w_num_ok),
        .o_digit  (w_digit),
        .o_zero   (w_zero)
    );

    function automatic logic [7:0] split_dec(input logic [5:0] v);
        logic [3:0] t;
        logic [5:0] o;
        t = (v >= 6'd50) ? 4'd5 : (v >= 6'd40) ? 4'd4 : (v >= 6'd30) ? 4'd3 :
            (v >= 6'd20) ? 4'd2 : (v >= 6'd10) ? 4'd1 : 4'd0;
        o = v - ({2'd0, t} * 6'd10);
        return {t, o[3:0]};
    endfunction

    always_comb begin
        logic        pos_ok;
        logic [2:0]  idx;
        logic [6:0]  g;
        logic [7:0]  hs;
        logic [7:0]  ms;
        int          k;
        for (int c = 0; c < SHOW_CELLS; c++) begin
            n_cell[c] = r_cell[c];
        end
        n_hours  = r_hours;
        n_min    = r_min;
        n_sec    = r_sec;
        n_status = STAT_OK;
        pos_ok   = (r_pos != 3'd0) && ({1'b0, r_pos} <= 4'(DIGIT_COUNT));
        idx      = r_pos - 3'd1;
        g        = (r_dval[7:4] == 4'd0) ? hex_glyph(r_dval[3:0]) : 7'd0;
        hs       = '0;
        ms       = '0;
        k        = 0;
        unique case (r_func)
            FUNC_SET_DIGIT: begin
                if (!pos_ok) begin
                    n_status = STAT_BAD_POS;
                end else if (r_dval[7:4] != 4'd0 && r_dval != BLANK_CODE) begin
                    n_status = STAT_BAD_DIG;
                end else begin
                    for (int c = 0; c < SHOW_CELLS; c++) begin
                        if (idx == 3'(c)) n_cell[c] = {r_cell[c][7], g};
                    end
                end
            end
            FUNC_SHOW_NUM: begin
                if (!w_num_ok) begin
                    n_status = STAT_BAD_NUM;
                end else begin
                    for (int c = 0; c < SHOW_CELLS; c++) begin
                        k = DIGIT_COUNT - 1 - c;
                        if (c < DIGIT_COUNT) begin
                            if (r_blank && k >= 1 && w_zero[3'(k - 1)]) begin
                                n_cell[c] = {r_cell[c][7], 7'd0};
                            end else begin
                                n_cell[c] = {r_cell[c][7], hex_glyph(w_digit[3'(k)])};
                            end
                        end
                    end
                end
            end
            FUNC_TICK: begin
                if (r_sec >= 6'd59) begin
                    n_sec = 6'd0;
                    if (r_min >= 6'd59) begin
                        n_min   = 6'd0;
                        n_hours = (r_hours >= 5'd23) ? 5'd0 : r_hours + 5'd1;
                    end else begin
                        n_min = r_min + 6'd1;
                    end
                end else begin
                    n_sec = r_sec + 6'd1;
                end
                ms = split_dec(n_min);
                hs = split_dec({1'b0, n_hours});
                n_cell[3] = {r_cell[3][7], hex_glyph(ms[3:0])};
                n_cell[2] = {r_cell[2][7], hex_glyph(ms[7:4])};
                n_cell[1] = {r_cell[1][7], hex_glyph(hs[3:0])};
                n_cell[0] = {r_cell[0][7], (hs[7:4] == 4'd0) ? 7'd0 : hex_glyph(hs[7:4])};
            end
            FUNC_DOTS_ON, FUNC_DOTS_OFF, FUNC_DOTS_TGL: begin
                for (int c = 0; c < SHOW_CELLS; c++) begin
                    if (r_mask[c]) begin
                        if (r_func == FUNC_DOTS_ON) begin
                            n_cell[c][7] = 1'b1;
                        end else if (r_func == FUNC_DOTS_OFF) begin
                            n_cell[c][7] = 1'b0;
                        end else begin
                            n_cell[c][7] = !r_cell[c][7];
                        end
                    end
                end
            end
            FUNC_CLEAR: begin
                for (int c = 0; c < SHOW_CELLS; c++) begin
                    n_cell[c] = '0;
                end
            end
            default: begin
                n_hours = (r_lh > 5'd23) ? 5'd23 : r_lh;
                n_min   = (r_lm > 6'd59) ? 6'd59 : r_lm;
                n_sec   = (r_ls > 6'd59) ? 6'd59 : r_ls;
            end
        endcase
        if (n_status != STAT_OK) begin
            n_cell[0] = {1'b0, GLYPH_E};
            n_cell[1] = {1'b0, GLYPH_R};
            n_cell[2] = {1'b1, GLYPH_R};
            n_cell[3] = {1'b0, hex_glyph({2'd0, n_status})};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_hours     <= '0;
            r_min       <= '0;
            r_sec       <= '0;
            for (int c = 0; c < SHOW_CELLS; c++) begin
                r_cell[c] <= '0;
            end
        end else begin
            if (s_tready) r_in_valid <= s_tvalid;
            if (w_adv) r_out_valid <= r_in_valid;
            if (w_fire) begin
                r_hours <= n_hours;
                r_min   <= n_min;
                r_sec   <= n_sec;
                for (int c = 0; c < SHOW_CELLS; c++) begin
                    r_cell[c] <= n_cell[c];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_func  <= s_tuser;
            r_dval  <= s_tdata[7:0];
            r_pos   <= s_tdata[10:8];
            r_num   <= s_tdata[34:11];
            r_base  <= s_tdata[39:35];
            r_blank <= s_tdata[40];
            r_mask  <= s_tdata[44:41];
            r_lh    <= s_tdata[49:45];
            r_lm    <= s_tdata[55:50];
            r_ls    <= s_tdata[61:56];
        end
        if (w_fire) begin
            r_out <= {5'd0, n_sec, n_min, n_hours, n_status,
                      n_cell[3], n_cell[2], n_cell[1], n_cell[0]};
        end
    end

endmodule

// File: tb/tb.sv
// Self-checking testbench for the four-digit segment display controller core.
`timescale 1ns / 1ps

module tb;
    import fdsd_pkg::*;

    typedef struct packed {
        logic [2:0]  op;
        logic [5:0]  ls;
        logic [5:0]  lm;
        logic [4:0]  lh;
        logic [3:0]  mask;
        logic        blank;
        logic [4:0]  radix;
        logic [23:0] num;
        logic [2:0]  pos;
        logic [7:0]  dval;
    } cmd_t;

    // same layout as m_tdata[50:0]
    typedef struct packed {
        logic [5:0] secs;
        logic [5:0] mins;
        logic [4:0] hrs;
        logic [1:0] status;
        logic [7:0] seg4;
        logic [7:0] seg3;
        logic [7:0] seg2;
        logic [7:0] seg1;
    } frame_t;

    localparam logic [16*7-1:0] SEG_FONT = {
        7'h71, 7'h79, 7'h5E, 7'h39, 7'h7C, 7'h77, 7'h6F, 7'h7F,
        7'h07, 7'h7D, 7'h6D, 7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F
    };
    localparam int RANDOM_CMDS = 1100;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;      // digit_value, position, number, base, blank_leading,
                                    // dot_mask, load_hours, load_minutes, load_seconds
    logic [2:0]  s_tuser = '0;      // func
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;           // segments 1..4, status, hours, minutes, seconds

    four_digit_segment_display_controller_core DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 i_clk = ~i_clk;

    cmd_t   pending_cmds[$];
    frame_t pending_frames[$];
    cmd_t   in_flight;
    int     cmd_total = 0;
    int     accepted = 0;
    int     mismatches = 0;
    int     src_gap = 0, src_span = 0, sink_hold = 0, sink_span = 0;
    bit     src_quiet = 1'b0, sink_quiet = 1'b0;

    // predicted block state
    logic [7:0] img [4];
    logic [4:0] hrs = '0;
    logic [5:0] mins = '0;
    logic [5:0] secs = '0;

    initial for (int k = 0; k < 4; k++) img[k] = 8'h00;

    function automatic logic [6:0] font(input logic [3:0] d);
        return SEG_FONT[int'(d)*7 +: 7];
    endfunction

    function automatic void put_seg(input int idx, input logic [6:0] glyph);
        img[idx] = {img[idx][7], glyph};
    endfunction

    function automatic frame_t update_display(input cmd_t c);
        logic [1:0]  st;
        logic [23:0] rem;
        logic        blanking;
        logic        ok;
        frame_t      f;
        st = STAT_OK;
        case (c.op)
            FUNC_SET_DIGIT: begin
                if (c.pos < 1 || c.pos > 4) st = STAT_BAD_POS;
                else if (c.dval < 16) put_seg(c.pos - 1, font(c.dval[3:0]));
                else if (c.dval == BLANK_CODE) put_seg(c.pos - 1, 7'h00);
                else st = STAT_BAD_DIG;
            end
            FUNC_SHOW_NUM: begin
                ok = (c.radix == 10 && c.num <= 9999) || (c.radix == 2 && c.num <= 15) ||
                     (c.radix == 8 && c.num <= 4095) || (c.radix == 16 && c.num <= 65535);
                if (!ok) begin
                    st = STAT_BAD_NUM;
                end else begin
                    rem = c.num;
                    blanking = 1'b0;
                    for (int k = 3; k >= 0; k--) begin
                        if (blanking) begin
                            put_seg(k, 7'h00);
                        end else begin
                            put_seg(k, font(4'(rem % 24'(c.radix))));
                            rem = rem / 24'(c.radix);
                            if (c.blank && rem == 0) blanking = 1'b1;
                        end
                    end
                end
            end
            FUNC_TICK: begin
                if (secs >= 59) begin
                    secs = 0;
                    if (mins >= 59) begin
                        mins = 0;
                        hrs = (hrs >= 23) ? 5'd0 : hrs + 5'd1;
                    end else begin
                        mins = mins + 6'd1;
                    end
                end else begin
                    secs = secs + 6'd1;
                end
                put_seg(3, font(4'(mins % 10)));
                put_seg(2, font(4'(mins / 10)));
                put_seg(1, font(4'(hrs % 10)));
                put_seg(0, (hrs / 10 != 0) ? font(4'(hrs / 10)) : 7'h00);
            end
            FUNC_DOTS_ON, FUNC_DOTS_OFF, FUNC_DOTS_TGL: begin
                for (int k = 0; k < 4; k++) begin
                    if (c.mask[k]) begin
                        if (c.op == FUNC_DOTS_ON) img[k][7] = 1'b1;
                        else if (c.op == FUNC_DOTS_OFF) img[k][7] = 1'b0;
                        else img[k][7] = ~img[k][7];
                    end
                end
            end
            FUNC_CLEAR: begin
                for (int k = 0; k < 4; k++) img[k] = 8'h00;
            end
            default: begin
                hrs  = (c.lh > 23) ? 5'd23 : c.lh;
                mins = (c.lm > 59) ? 6'd59 : c.lm;
                secs = (c.ls > 59) ? 6'd59 : c.ls;
            end
        endcase
        if (st != STAT_OK) begin
            img[0] = {1'b0, GLYPH_E};
            img[1] = {1'b0, GLYPH_R};
            img[2] = {1'b1, GLYPH_R};
            img[3] = {1'b0, font({2'b00, st})};
        end
        f.seg1 = img[0];
        f.seg2 = img[1];
        f.seg3 = img[2];
        f.seg4 = img[3];
        f.status = st;
        f.hrs = hrs;
        f.mins = mins;
        f.secs = secs;
        return f;
    endfunction

    function automatic cmd_t mk(input logic [2:0] op, input logic [7:0] dval,
                                input logic [2:0] pos, input logic [23:0] num,
                                input logic [4:0] radix, input logic blank,
                                input logic [3:0] mask, input logic [4:0] lh,
                                input logic [5:0] lm, input logic [5:0] ls);
        cmd_t c;
        c = '{op: op, ls: ls, lm: lm, lh: lh, mask: mask, blank: blank,
              radix: radix, num: num, pos: pos, dval: dval};
        return c;
    endfunction

    function automatic cmd_t rand_cmd();
        cmd_t c;
        int   r;
        logic [23:0] lim;
        c.op    = 3'($urandom_range(0, 7));
        c.dval  = 8'($urandom);
        c.pos   = 3'($urandom);
        c.num   = 24'($urandom);
        c.radix = 5'($urandom);
        c.blank = 1'($urandom);
        c.mask  = 4'($urandom);
        c.lh    = 5'($urandom);
        c.lm    = 6'($urandom);
        c.ls    = 6'($urandom);
        case (c.op)
            FUNC_SET_DIGIT: begin
                if ($urandom_range(0, 9) < 8) c.pos = 3'($urandom_range(1, 4));
                r = $urandom_range(0, 99);
                if (r < 70) c.dval = 8'($urandom_range(0, 15));
                else if (r < 85) c.dval = BLANK_CODE;
            end
            FUNC_SHOW_NUM: begin
                if ($urandom_range(0, 99) < 85) begin
                    case ($urandom_range(0, 3))
                        0: begin c.radix = 5'd2;  lim = 24'd15;    end
                        1: begin c.radix = 5'd8;  lim = 24'd4095;  end
                        2: begin c.radix = 5'd10; lim = 24'd9999;  end
                        default: begin c.radix = 5'd16; lim = 24'd65535; end
                    endcase
                    r = $urandom_range(0, 99);
                    if (r < 60) c.num = 24'($urandom_range(0, lim));
                    else if (r < 80) c.num = 24'($urandom_range(0, 20));
                    else if (r < 90) c.num = lim + 24'($urandom_range(0, 1));
                end
            end
            FUNC_LOAD_TIME: begin
                if ($urandom_range(0, 9) < 8) begin
                    c.lh = 5'($urandom_range(0, 23));
                    c.lm = 6'($urandom_range(0, 59));
                    c.ls = 6'($urandom_range(0, 59));
                end
            end
            default: ;
        endcase
        return c;
    endfunction

    function automatic int pick_pause(input bit quiet);
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // source side
    always @(posedge i_clk) begin
        logic fire_next;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            fire_next = s_tvalid;
            if (s_tvalid && s_tready) begin
                pending_frames.push_back(update_display(in_flight));
                accepted++;
                fire_next = 1'b0;
            end
            if (src_span == 0) begin
                src_quiet = ($urandom_range(0, 3) == 0);
                src_span = $urandom_range(20, 200);
            end else begin
                src_span--;
            end
            if (!fire_next) begin
                if (src_gap > 0) begin
                    src_gap--;
                end else if (pending_cmds.size() != 0) begin
                    in_flight = pending_cmds.pop_front();
                    s_tuser <= in_flight.op;
                    s_tdata <= {2'b00, in_flight.ls, in_flight.lm, in_flight.lh, in_flight.mask,
                                in_flight.blank, in_flight.radix, in_flight.num, in_flight.pos,
                                in_flight.dval};
                    fire_next = 1'b1;
                    src_gap = pick_pause(src_quiet);
                end
            end
            s_tvalid <= fire_next;
        end
    end

    // result side
    always @(posedge i_clk) begin
        frame_t got, want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[50:0];
                if (pending_frames.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                    mismatches++;
                end else begin
                    want = pending_frames.pop_front();
                    check_field("segments_digit1", want.seg1, got.seg1);
                    check_field("segments_digit2", want.seg2, got.seg2);
                    check_field("segments_digit3", want.seg3, got.seg3);
                    check_field("segments_digit4", want.seg4, got.seg4);
                    check_field("status", 8'(want.status), 8'(got.status));
                    check_field("hours_now", 8'(want.hrs), 8'(got.hrs));
                    check_field("minutes_now", 8'(want.mins), 8'(got.mins));
                    check_field("seconds_now", 8'(want.secs), 8'(got.secs));
                end
            end
            if (sink_span == 0) begin
                sink_quiet = ($urandom_range(0, 3) == 0);
                sink_span = $urandom_range(20, 200);
            end else begin
                sink_span--;
            end
            if (sink_hold > 0) begin
                sink_hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                sink_hold = pick_pause(sink_quiet);
            end
        end
    end

    initial begin
        int n;
        int ticks;
        pending_cmds.push_back(mk(FUNC_CLEAR,     8'd0,   3'd0, 24'd0, 5'd0, 1'b0, 4'h0, 0, 0, 0));
        pending_cmds.push_back(mk(FUNC_SET_DIGIT, 8'd0,   3'd1, 24'd0, 5'd0, 1'b0, 4'h0, 0, 0, 0));
        pending_cmds.push_back(mk(FUNC_SET_DIGIT, 8'd15,  3'd4, 24'd0, 5'd0, 1'b0, 4'h0, 0, 0, 0));
        pending_cmds.push_back(mk(FUNC_SET_DIGIT, 8'd255, 3'd2, 24'd0, 5'd0, 1'b0, 4'h0, 0, 0, 0));
        pending_cmds.push_back(mk(FUNC_SET_DIGIT, 8'd16,  3'd3, 24'd0, 5'd0, 1'b0, 4'h0, 0, 0, 0));
        pending_cmds.push_back(mk(FUNC_SET_DIGIT, 8'd5,   3'd0, 24'd0, 5'd0, 1'b0, 4'h0, 0, 0, 0));
        pending_cmds.push_back(mk(FUNC_SET_DIGIT, 8'd254, 3'd7, 24'd0, 5'd0, 1'b0, 4'h0, 0, 0, 0));
        pending_cmds.push_back(mk(FUNC_SET_DIGIT, 8'd254, 3'd3, 24'd0, 5'd0, 1'b0, 4'h0, 0, 0, 0));
        pending_cmds.push_back(mk(FUNC_DOTS_ON,   8'd0,   3'd0, 24'd0, 5'd0, 1'b0, 4'hF, 0, 0, 0));
        pending_cmds.push_back(mk(FUNC_SET_DIGIT, 8'd9,   3'd1, 24'd0, 5'd0, 1'b0, 4'h0, 0, 0, 0));
        pending_cmds.push_back(mk(FUNC_DOTS_TGL,  8'd0,   3'd0, 24'd0, 5'd0, 1'b0, 4'h5, 0, 0, 0));
        pending_cmds.push_back(mk(FUNC_SHOW_NUM,  8'd0, 3'd0, 24'd65535, 5'd16, 1'b0, 4'h0, 0, 0, 0));
        pending_cmds.push_back(mk(FUNC_DOTS_OFF,  8'd0,   3'd0, 24'd0, 5'd0, 1'b0, 4'hF, 0, 0, 0));
        pending_cmds.push_back(mk(FUNC_SHOW_NUM,  8'd0, 3'd0, 24'd65536, 5'd16, 1'b0, 4'h0, 0, 0, 0));
        pending_cmds.push_back(mk(FUNC_SHOW_NUM,  8'd0, 3'd0, 24'd9999, 5'd10, 1'b1, 4'h0, 0, 0, 0));
        pending_cmds.push_back(mk(FUNC_SHOW_NUM,  8'd0, 3'd0, 24'd10000, 5'd10, 1'b0, 4'h0, 0, 0, 0));
        pending_cmds.push_back(mk(FUNC_SHOW_NUM,  8'd0, 3'd0, 24'd15, 5'd2, 1'b0, 4'h0, 0, 0, 0));
        pending_cmds.push_back(mk(FUNC_SHOW_NUM,  8'd0, 3'd0, 24'd16, 5'd2, 1'b0, 4'h0, 0, 0, 0));
        pending_cmds.push_back(mk(FUNC_SHOW_NUM,  8'd0, 3'd0, 24'd4095, 5'd8, 1'b1, 4'h0, 0, 0, 0));
        pending_cmds.push_back(mk(FUNC_SHOW_NUM,  8'd0, 3'd0, 24'd0, 5'd8, 1'b1, 4'h0, 0, 0, 0));
        pending_cmds.push_back(mk(FUNC_SHOW_NUM,  8'd0, 3'd0, 24'hFFFFFF, 5'd31, 1'b1, 4'h0, 0, 0, 0));
        pending_cmds.push_back(mk(FUNC_SHOW_NUM,  8'd0, 3'd0, 24'd0, 5'd0, 1'b0, 4'h0, 0, 0, 0));
        pending_cmds.push_back(mk(FUNC_LOAD_TIME, 8'd0, 3'd0, 24'd0, 5'd0, 1'b0, 4'h0, 31, 63, 63));
        pending_cmds.push_back(mk(FUNC_TICK,      8'd0, 3'd0, 24'd0, 5'd0, 1'b0, 4'h0, 0, 0, 0));
        pending_cmds.push_back(mk(FUNC_LOAD_TIME, 8'd0, 3'd0, 24'd0, 5'd0, 1'b0, 4'h0, 9, 59, 59));
        pending_cmds.push_back(mk(FUNC_TICK,      8'd0, 3'd0, 24'd0, 5'd0, 1'b0, 4'h0, 0, 0, 0));

        n = 0;
        while (n < RANDOM_CMDS) begin
            if ($urandom_range(0, 19) == 0) begin
                // run the clock across a minute, hour or day boundary
                pending_cmds.push_back(mk(FUNC_LOAD_TIME, 8'($urandom), 3'($urandom),
                    24'($urandom), 5'($urandom), 1'($urandom), 4'($urandom),
                    5'($urandom_range(8, 23)), 6'($urandom_range(58, 59)),
                    6'($urandom_range(55, 59))));
                ticks = $urandom_range(2, 8);
                for (int k = 0; k < ticks; k++) begin
                    pending_cmds.push_back(mk(FUNC_TICK, 8'($urandom), 3'($urandom),
                        24'($urandom), 5'($urandom), 1'($urandom), 4'($urandom),
                        5'($urandom), 6'($urandom), 6'($urandom)));
                end
                n += ticks + 1;
            end else begin
                pending_cmds.push_back(rand_cmd());
                n++;
            end
        end
        cmd_total = pending_cmds.size();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted != cmd_total || pending_frames.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("four_digit_segment_display_controller_core regression: pass");
        end else begin
            $display("four_digit_segment_display_controller_core regression: fail");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("%0t: timeout, %0d results still expected", $time, pending_frames.size());
        $display("four_digit_segment_display_controller_core regression: fail");
        $finish;
    end

endmodule

// File: sim.f
rtl/fdsd_pkg.sv
rtl/fdsd_num_conv.sv
rtl/four_digit_segment_display_controller_core.sv
tb/tb.sv
